### sv/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
`default_nettype none
package fbpa_pkg;

  localparam int NUM_BLOCKS_DEF = 128;
  localparam int MAX_STACK      = 128;

  // request codes
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_REFORM = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SIZE   = 2'd1;
  localparam logic [1:0] CFG_BLOCK_COUNT  = 2'd2;

  localparam logic [16:0] SIZE_MIN = 17'd8;
  localparam logic [16:0] SIZE_MAX = 17'd65536;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] block_index;
    logic       ptr_null;
  } fbpa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  granted_index;
    logic [31:0] granted_address;
  } fbpa_rsp_t;

  // stack control from the request decoder to the cell chain
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [6:0] push_data;
  } fbpa_stk_ctrl_t;

endpackage
`default_nettype wire

### sv/fbpa_cell.sv
// One stack cell: holds one freed block index and shifts with its neighbors.
`default_nettype none
module fbpa_cell (
  input  wire logic       clk,
  input  wire logic       push,
  input  wire logic       pop,
  input  wire logic [6:0] from_above,
  input  wire logic [6:0] from_below,
  output logic [6:0]      value
);
  import fbpa_pkg::*;

  logic [6:0] value_r;
  logic [6:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (push) begin
      value_nxt = from_above;
    end else if (pop) begin
      value_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule
`default_nettype wire

### sv/fbpa_stack.sv
// Freed-block LIFO built as a shifting chain of cells; cell 0 is the top.
`default_nettype none
module fbpa_stack #(
  parameter int DEPTH = fbpa_pkg::MAX_STACK
) (
  input  wire logic                     clk,
  input  wire fbpa_pkg::fbpa_stk_ctrl_t ctrl,
  output logic [6:0]                    top
);
  import fbpa_pkg::*;

  logic [6:0] cell_val [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [6:0] above;
    logic [6:0] below;
    if (i == 0) begin : g_first
      assign above = ctrl.push_data;
    end else begin : g_mid
      assign above = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = cell_val[i];
    end else begin : g_inner
      assign below = cell_val[i+1];
    end
    fbpa_cell u_cell (
      .clk        (clk),
      .push       (ctrl.push),
      .pop        (ctrl.pop),
      .from_above (above),
      .from_below (below),
      .value      (cell_val[i])
    );
  end

  assign top = cell_val[0];

endmodule
`default_nettype wire

### sv/fixed_block_pool_allocator.sv
// Fixed block pool allocator top level: request decode, address calc, result register.
// An accepted request's result is captured in the output register in the next cycle.
// Throughput: one request per cycle while in_stall is low; the freed-block stack pushes
// or pops one entry per cycle by shifting its whole cell chain.
// Reset (rst_n low, synchronous): pool empty of freed blocks, fresh pointer at 0,
// registers at base 0, block size 8, block count 128; no clearing pass.
`default_nettype none
module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire fbpa_pkg::fbpa_req_t in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output fbpa_pkg::fbpa_rsp_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import fbpa_pkg::*;

  localparam int STACK_DEPTH = (NUM_BLOCKS < MAX_STACK) ? NUM_BLOCKS : MAX_STACK;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  logic [31:0] base_address_r;
  logic [16:0] block_size_r;
  logic [7:0]  block_count_r;

  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic             out_valid_r, out_valid_nxt;
  fbpa_rsp_t        out_data_r, out_data_nxt;

  fbpa_stk_ctrl_t   stk_ctrl;
  logic [6:0]       stk_top;
  logic             in_accept;
  logic [CNT_W-1:0] eff_count;
  logic [16:0]      eff_size;
  logic [6:0]       blk;
  logic             got;
  logic [23:0]      offset;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r <= '0;
      block_size_r   <= SIZE_MIN;
      block_count_r  <= 8'(MAX_STACK);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_ADDRESS: base_address_r <= cfg_data;
        CFG_BLOCK_SIZE:   block_size_r   <= cfg_data[16:0];
        CFG_BLOCK_COUNT:  block_count_r  <= cfg_data[7:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    if (block_count_r == 8'd0) begin
      eff_count = CNT_W'(1);
    end else if (block_count_r > 8'(STACK_DEPTH)) begin
      eff_count = CNT_W'(STACK_DEPTH);
    end else begin
      eff_count = CNT_W'(block_count_r);
    end
    if (block_size_r < SIZE_MIN) begin
      eff_size = SIZE_MIN;
    end else if (block_size_r > SIZE_MAX) begin
      eff_size = SIZE_MAX;
    end else begin
      eff_size = block_size_r;
    end
  end

  // request decode: stack control, pointer updates and result fields
  always_comb begin
    stk_ctrl      = '0;
    depth_nxt     = depth_r;
    fresh_nxt     = fresh_r;
    blk           = '0;
    got           = 1'b0;
    out_data_nxt  = '0;
    stk_ctrl.push_data = in_data.block_index;
    case (in_data.req_type)
      REQ_ALLOC: begin
        if (depth_r != '0) begin
          stk_ctrl.pop = in_accept;
          depth_nxt    = depth_r - CNT_W'(1);
          blk          = stk_top;
          got          = 1'b1;
        end else if (fresh_r < eff_count) begin
          fresh_nxt = fresh_r + CNT_W'(1);
          blk       = 7'(fresh_r);
          got       = 1'b1;
        end
        out_data_nxt.status = got ? ST_OK : ST_EMPTY;
      end
      REQ_FREE: begin
        if (!in_data.ptr_null) begin
          if ((8'(in_data.block_index) >= 8'(eff_count)) || (depth_r >= eff_count)) begin
            out_data_nxt.status = ST_IGNORED;
          end else begin
            stk_ctrl.push = in_accept;
            depth_nxt     = depth_r + CNT_W'(1);
          end
        end
      end
      REQ_REFORM: begin
        depth_nxt = '0;
        fresh_nxt = '0;
      end
      default: begin
        out_data_nxt.status = ST_IGNORED;
      end
    endcase
    offset = 24'(blk) * 24'(eff_size);
    if (got) begin
      out_data_nxt.granted_index   = blk;
      out_data_nxt.granted_address = base_address_r + 32'(offset);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        depth_r <= depth_nxt;
        fresh_r <= fresh_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  fbpa_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .ctrl (stk_ctrl),
    .top  (stk_top)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctrl.pop |-> (depth_r != '0))
    else $error("pop issued on empty freed stack");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctrl.push |-> (depth_r < eff_count) && !stk_ctrl.pop)
    else $error("push issued on full freed stack");

  a_reform_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.req_type == REQ_REFORM) |=> (depth_r == '0) && (fresh_r == '0))
    else $error("pool re-form did not clear pointers");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |->
      (out_data_r.granted_index == '0) && (out_data_r.granted_address == '0))
    else $error("failed request carries a grant");

endmodule
`default_nettype wire
